### sv/jsv_pkg.sv
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types, codes and small lookup functions of the JSON stream validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

	localparam int MAX_DEPTH_DEF        = 32;
	localparam int MAX_NUMBER_CHARS_DEF = 64;
	localparam int QUEUE_DEPTH          = 4;
	localparam int EV_SLOTS             = 4;

	// event codes
	localparam logic [3:0] EV_NONE      = 4'd0;
	localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
	localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
	localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
	localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
	localparam logic [3:0] EV_KEY_START = 4'd5;
	localparam logic [3:0] EV_STR_START = 4'd6;
	localparam logic [3:0] EV_STR_BYTE  = 4'd7;
	localparam logic [3:0] EV_STR_END   = 4'd8;
	localparam logic [3:0] EV_INT_END   = 4'd9;
	localparam logic [3:0] EV_FLOAT_END = 4'd10;
	localparam logic [3:0] EV_TRUE      = 4'd11;
	localparam logic [3:0] EV_FALSE     = 4'd12;
	localparam logic [3:0] EV_NULL      = 4'd13;

	// error codes
	localparam logic [2:0] ERR_OK     = 3'd0;
	localparam logic [2:0] ERR_SYNTAX = 3'd1;
	localparam logic [2:0] ERR_DEPTH  = 3'd2;
	localparam logic [2:0] ERR_NODES  = 3'd3;
	localparam logic [2:0] ERR_LEN    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_DEPTH_LIMIT  = 2'd0;
	localparam logic [1:0] CFG_NODE_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

	localparam logic [5:0]  DEPTH_LIMIT_RST  = 6'd32;
	localparam logic [13:0] NODE_LIMIT_RST   = 14'd10000;
	localparam logic [20:0] LENGTH_LIMIT_RST = 21'd1048576;

	localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [3:0] code;
		logic [7:0] data;
		logic [5:0] depth;
	} ev_t;

	// all events caused by one input byte
	typedef struct packed {
		ev_t [EV_SLOTS-1:0] ev;
		logic [2:0]         cnt;
		logic [63:0]        ival;
		logic [2:0]         err;
		logic               done;
	} bundle_t;

	function automatic ev_t mk_ev(logic [3:0] code, logic [7:0] data, logic [5:0] depth);
		ev_t e;
		e.code  = code;
		e.data  = data;
		e.depth = depth;
		return e;
	endfunction

	// magnitude * 10 + digit, saturating at 2^63
	function automatic logic [63:0] mul10_add(logic [63:0] a, logic [3:0] d);
		logic [67:0] t;
		t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + 68'(d);
		if (t > 68'(MAG_CAP)) return MAG_CAP;
		return t[63:0];
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= "0" && c <= "9") begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end
		if (c >= "a" && c <= "f") begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end
		if (c >= "A" && c <= "F") begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	// literal letters: 0 true, 1 false, 2 null
	function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] i);
		case ({k, i})
			{2'd0, 3'd0}: return "t";
			{2'd0, 3'd1}: return "r";
			{2'd0, 3'd2}: return "u";
			{2'd0, 3'd3}: return "e";
			{2'd1, 3'd0}: return "f";
			{2'd1, 3'd1}: return "a";
			{2'd1, 3'd2}: return "l";
			{2'd1, 3'd3}: return "s";
			{2'd1, 3'd4}: return "e";
			{2'd2, 3'd0}: return "n";
			{2'd2, 3'd1}: return "u";
			{2'd2, 3'd2}: return "l";
			{2'd2, 3'd3}: return "l";
			default:      return 8'd0;
		endcase
	endfunction

endpackage

### sv/jsv_front.sv
// ----------------------------------------------------------------------------
// jsv_front
// Byte lexer: checks syntax and limits, builds the event bundle of each byte.
// ----------------------------------------------------------------------------
module jsv_front #(
	parameter int MAX_DEPTH        = jsv_pkg::MAX_DEPTH_DEF,
	parameter int MAX_NUMBER_CHARS = jsv_pkg::MAX_NUMBER_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              in_end,
	input  logic [5:0]        depth_limit,
	input  logic [13:0]       node_limit,
	input  logic [20:0]       length_limit,
	output logic              push,
	output jsv_pkg::bundle_t  bundle
);

	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int SIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int NLW = $clog2(MAX_NUMBER_CHARS + 1);

	typedef enum logic [4:0] {
		ST_VTOP = 5'd0, ST_VFIRSTARR = 5'd1, ST_VELEM = 5'd2, ST_KFIRST = 5'd3,
		ST_KNEXT = 5'd4, ST_COLON = 5'd5, ST_AFTER = 5'd6, ST_SCHAR = 5'd7,
		ST_SESC = 5'd8, ST_SHEX = 5'd9, ST_LOWBS = 5'd10, ST_LOWU = 5'd11,
		ST_LOWHEX = 5'd12, ST_NSIGN = 5'd13, ST_NZERO = 5'd14, ST_NINT = 5'd15,
		ST_NDOT = 5'd16, ST_NFRAC = 5'd17, ST_NEXP = 5'd18, ST_NEXPSIGN = 5'd19,
		ST_NEXPDIG = 5'd20, ST_LTRUE = 5'd21, ST_LFALSE = 5'd22, ST_LNULL = 5'd23
	} lex_state_t;

	localparam int FL_NEG = 0, FL_FLOAT = 1, FL_KEY = 2;

	lex_state_t           st_q, st, s;
	logic [DW-1:0]        dep_q, dep, lim, dm1;
	logic [13:0]          node_q, node;
	logic [20:0]          bc_q, bc;
	logic [15:0]          hex_q, hx;
	logic [9:0]           hs_q, hs;
	logic [63:0]          acc_q, acc, ival;
	logic [NLW-1:0]       nlen_q, nlen;
	logic [2:0]           flg_q, flg, lit_q, lit, err_q, err, n;
	logic [MAX_DEPTH-1:0] stk_q;
	logic                 stk_we, stk_val, top_obj, go, taken, dig, ws, do_utf;
	logic [SIW-1:0]       stk_idx;
	logic [4:0]           hv;
	logic [20:0]          cp;
	logic [1:0]           k;
	logic [2:0]           llen;
	logic [3:0]           lev;
	logic [7:0]           c, eo;
	jsv_pkg::ev_t         ev [jsv_pkg::EV_SLOTS];

	assign c       = in_byte;
	assign dm1     = dep_q - DW'(1);
	assign top_obj = stk_q[dm1[SIW-1:0]];
	assign lim     = ({3'b0, depth_limit} > 9'(MAX_DEPTH)) ? DW'(MAX_DEPTH) : DW'(depth_limit);

	always_comb begin
		st = st_q; dep = dep_q; node = node_q; hx = hex_q; hs = hs_q; acc = acc_q;
		nlen = nlen_q; flg = flg_q; lit = lit_q; err = err_q;
		stk_we = 1'b0; stk_val = 1'b0; stk_idx = '0; n = 3'd0; ival = 64'd0;
		for (int i = 0; i < jsv_pkg::EV_SLOTS; i++) ev[i] = '0;
		s = st_q; go = 1'b0; taken = 1'b1; do_utf = 1'b0; cp = 21'd0; k = 2'd0;
		llen = 3'd4; lev = jsv_pkg::EV_TRUE; eo = 8'd0;
		dig = (c >= "0") && (c <= "9");
		ws  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
		hv  = jsv_pkg::hex_val(c);
		bc  = (&bc_q) ? bc_q : bc_q + 21'd1;
		if (bc > length_limit) err = jsv_pkg::ERR_LEN;

		if (err == jsv_pkg::ERR_OK) begin
			go = 1'b1;
			if (s >= ST_NSIGN && s <= ST_NEXPDIG) begin
				go = 1'b0;
				if (s == ST_NSIGN || s == ST_NDOT || s == ST_NEXPSIGN) begin
					if (!dig) err = jsv_pkg::ERR_SYNTAX;
					else begin
						if (s == ST_NSIGN) begin
							st = (c == "0") ? ST_NZERO : ST_NINT;
							acc = jsv_pkg::mul10_add(acc, c[3:0]);
						end else st = (s == ST_NDOT) ? ST_NFRAC : ST_NEXPDIG;
						nlen = nlen + NLW'(1);
						if (nlen >= NLW'(MAX_NUMBER_CHARS)) err = jsv_pkg::ERR_SYNTAX;
					end
				end else if (s == ST_NEXP) begin
					if (c == "+" || c == "-" || dig) begin
						st = dig ? ST_NEXPDIG : ST_NEXPSIGN;
						nlen = nlen + NLW'(1);
						if (nlen >= NLW'(MAX_NUMBER_CHARS)) err = jsv_pkg::ERR_SYNTAX;
					end else err = jsv_pkg::ERR_SYNTAX;
				end else if (dig && s != ST_NZERO) begin
					if (s == ST_NINT) acc = jsv_pkg::mul10_add(acc, c[3:0]);
					nlen = nlen + NLW'(1);
					if (nlen >= NLW'(MAX_NUMBER_CHARS)) err = jsv_pkg::ERR_SYNTAX;
				end else if ((c == "." && (s == ST_NZERO || s == ST_NINT)) ||
				             ((c == "e" || c == "E") && s != ST_NEXPDIG)) begin
					flg[FL_FLOAT] = 1'b1;
					st = (c == ".") ? ST_NDOT : ST_NEXP;
					nlen = nlen + NLW'(1);
					if (nlen >= NLW'(MAX_NUMBER_CHARS)) err = jsv_pkg::ERR_SYNTAX;
				end else taken = 1'b0;

				// number ended before this byte
				if (!taken) begin
					if (node >= node_limit) err = jsv_pkg::ERR_NODES;
					else begin
						node = node + 14'd1;
						if (flg[FL_FLOAT]) begin
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_FLOAT_END, 8'd0, 6'(dep));
						end else begin
							if (flg[FL_NEG]) ival = acc[63] ? jsv_pkg::MAG_CAP : (~acc + 64'd1);
							else ival = acc[63] ? (jsv_pkg::MAG_CAP - 64'd1) : acc;
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_INT_END, 8'd0, 6'(dep));
						end
						n = n + 3'd1;
						st = ST_AFTER;
					end
					go = (err == jsv_pkg::ERR_OK);
					s = ST_AFTER;
				end
			end
			if (go && s <= ST_AFTER && ws) go = 1'b0;

			if (go) begin
				case (s)
					ST_VTOP, ST_VELEM, ST_VFIRSTARR, ST_KFIRST, ST_AFTER: begin
						if ((s == ST_VFIRSTARR || s == ST_AFTER) && c == "]" ||
						    (s == ST_KFIRST || s == ST_AFTER) && c == "}") begin
							if (dep_q == '0 || top_obj != (c == "}")) err = jsv_pkg::ERR_SYNTAX;
							else begin
								dep = dep - DW'(1);
								ev[n[1:0]] = jsv_pkg::mk_ev((c == "}") ? jsv_pkg::EV_OBJ_CLOSE :
									jsv_pkg::EV_ARR_CLOSE, 8'd0, 6'(dep));
								n = n + 3'd1;
								st = ST_AFTER;
							end
						end else if (s == ST_AFTER) begin
							if (c == "," && dep_q != '0) st = top_obj ? ST_KNEXT : ST_VELEM;
							else err = jsv_pkg::ERR_SYNTAX;
						end else if (s == ST_KFIRST) begin
							if (c == "\"") begin
								flg = 3'b100;
								ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_KEY_START, 8'd0, 6'(dep));
								n = n + 3'd1;
								st = ST_SCHAR;
							end else err = jsv_pkg::ERR_SYNTAX;
						end else if (c == "{" || c == "[") begin
							if (dep >= lim) err = jsv_pkg::ERR_DEPTH;
							else if (node >= node_limit) err = jsv_pkg::ERR_NODES;
							else begin
								node = node + 14'd1;
								stk_we = 1'b1; stk_idx = dep[SIW-1:0]; stk_val = (c == "{");
								dep = dep + DW'(1);
								ev[n[1:0]] = jsv_pkg::mk_ev((c == "{") ? jsv_pkg::EV_OBJ_OPEN :
									jsv_pkg::EV_ARR_OPEN, 8'd0, 6'(dep));
								n = n + 3'd1;
								st = (c == "{") ? ST_KFIRST : ST_VFIRSTARR;
							end
						end else if (c == "\"") begin
							if (node >= node_limit) err = jsv_pkg::ERR_NODES;
							else begin
								node = node + 14'd1;
								flg = 3'b000;
								ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_START, 8'd0, 6'(dep));
								n = n + 3'd1;
								st = ST_SCHAR;
							end
						end else if (c == "t" || c == "f" || c == "n") begin
							st = (c == "t") ? ST_LTRUE : (c == "f") ? ST_LFALSE : ST_LNULL;
							lit = 3'd1;
						end else if (c == "-" || dig) begin
							acc = dig ? {60'd0, c[3:0]} : 64'd0;
							nlen = NLW'(1);
							flg = (c == "-") ? 3'b001 : 3'b000;
							st = (c == "-") ? ST_NSIGN : (c == "0") ? ST_NZERO : ST_NINT;
						end else err = jsv_pkg::ERR_SYNTAX;
					end
					ST_KNEXT: begin
						if (c == "\"") begin
							flg = 3'b100;
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_KEY_START, 8'd0, 6'(dep));
							n = n + 3'd1;
							st = ST_SCHAR;
						end else err = jsv_pkg::ERR_SYNTAX;
					end
					ST_COLON: begin
						if (c == ":") st = ST_VELEM;
						else err = jsv_pkg::ERR_SYNTAX;
					end
					ST_SCHAR: begin
						if (c == "\"") begin
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_END, 8'd0, 6'(dep));
							n = n + 3'd1;
							st = flg[FL_KEY] ? ST_COLON : ST_AFTER;
						end else if (c == "\\") st = ST_SESC;
						else if (c < 8'h20) err = jsv_pkg::ERR_SYNTAX;
						else begin
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, c, 6'(dep));
							n = n + 3'd1;
						end
					end
					ST_SESC: begin
						case (c)
							"\"", "\\", "/": eo = c;
							"b": eo = 8'h08;
							"f": eo = 8'h0C;
							"n": eo = 8'h0A;
							"r": eo = 8'h0D;
							"t": eo = 8'h09;
							default: eo = 8'h00;
						endcase
						if (c == "u") begin
							hx = 16'd0; lit = 3'd0; st = ST_SHEX;
						end else if (eo == 8'h00) err = jsv_pkg::ERR_SYNTAX;
						else begin
							ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, eo, 6'(dep));
							n = n + 3'd1;
							st = ST_SCHAR;
						end
					end
					ST_SHEX, ST_LOWHEX: begin
						if (!hv[4]) err = jsv_pkg::ERR_SYNTAX;
						else begin
							hx = {hx[11:0], hv[3:0]};
							lit = lit + 3'd1;
							if (lit == 3'd4) begin
								if (s == ST_SHEX) begin
									if (hx[15:10] == 6'b110110) begin
										hs = hx[9:0]; st = ST_LOWBS;
									end else if (hx[15:10] == 6'b110111) err = jsv_pkg::ERR_SYNTAX;
									else begin
										cp = {5'd0, hx}; do_utf = 1'b1;
									end
								end else if (hx[15:10] != 6'b110111) err = jsv_pkg::ERR_SYNTAX;
								else begin
									cp = 21'h10000 + {1'b0, hs, 10'd0} + {11'd0, hx[9:0]};
									do_utf = 1'b1;
								end
							end
						end
						// nothing was emitted earlier for this byte
						if (do_utf) begin
							st = ST_SCHAR;
							if (cp <= 21'h7F) begin
								ev[0] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, cp[7:0], 6'(dep));
								n = 3'd1;
							end else if (cp <= 21'h7FF) begin
								ev[0] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {3'b110, cp[10:6]}, 6'(dep));
								ev[1] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 6'(dep));
								n = 3'd2;
							end else if (cp <= 21'hFFFF) begin
								ev[0] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {4'b1110, cp[15:12]}, 6'(dep));
								ev[1] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[11:6]}, 6'(dep));
								ev[2] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 6'(dep));
								n = 3'd3;
							end else begin
								ev[0] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {5'b11110, cp[20:18]}, 6'(dep));
								ev[1] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[17:12]}, 6'(dep));
								ev[2] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[11:6]}, 6'(dep));
								ev[3] = jsv_pkg::mk_ev(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 6'(dep));
								n = 3'd4;
							end
						end
					end
					ST_LOWBS: begin
						if (c == "\\") st = ST_LOWU;
						else err = jsv_pkg::ERR_SYNTAX;
					end
					ST_LOWU: begin
						if (c == "u") begin
							hx = 16'd0; lit = 3'd0; st = ST_LOWHEX;
						end else err = jsv_pkg::ERR_SYNTAX;
					end
					ST_LTRUE, ST_LFALSE, ST_LNULL: begin
						k    = (s == ST_LTRUE) ? 2'd0 : (s == ST_LFALSE) ? 2'd1 : 2'd2;
						llen = (s == ST_LFALSE) ? 3'd5 : 3'd4;
						lev  = (s == ST_LTRUE) ? jsv_pkg::EV_TRUE :
						       (s == ST_LFALSE) ? jsv_pkg::EV_FALSE : jsv_pkg::EV_NULL;
						if (lit >= llen || c != jsv_pkg::lit_char(k, lit)) err = jsv_pkg::ERR_SYNTAX;
						else begin
							lit = lit + 3'd1;
							if (lit == llen) begin
								if (node >= node_limit) err = jsv_pkg::ERR_NODES;
								else begin
									node = node + 14'd1;
									ev[n[1:0]] = jsv_pkg::mk_ev(lev, 8'd0, 6'(dep));
									n = n + 3'd1;
									st = ST_AFTER;
								end
							end
						end
					end
					default: err = jsv_pkg::ERR_SYNTAX;
				endcase
			end
		end

		if (in_end) begin
			if (err == jsv_pkg::ERR_OK &&
			    (st == ST_NZERO || st == ST_NINT || st == ST_NFRAC || st == ST_NEXPDIG)) begin
				if (node >= node_limit) err = jsv_pkg::ERR_NODES;
				else begin
					node = node + 14'd1;
					if (flg[FL_FLOAT]) begin
						ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_FLOAT_END, 8'd0, 6'(dep));
					end else begin
						if (flg[FL_NEG]) ival = acc[63] ? jsv_pkg::MAG_CAP : (~acc + 64'd1);
						else ival = acc[63] ? (jsv_pkg::MAG_CAP - 64'd1) : acc;
						ev[n[1:0]] = jsv_pkg::mk_ev(jsv_pkg::EV_INT_END, 8'd0, 6'(dep));
					end
					n = n + 3'd1;
					st = ST_AFTER;
				end
			end
			if (err == jsv_pkg::ERR_OK && !(st == ST_AFTER && dep == '0)) err = jsv_pkg::ERR_SYNTAX;
			if (n == 3'd0) begin
				ev[0] = jsv_pkg::mk_ev(jsv_pkg::EV_NONE, 8'd0, 6'(dep));
				n = 3'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < jsv_pkg::EV_SLOTS; i++) bundle.ev[i] = ev[i];
		bundle.cnt  = n;
		bundle.ival = ival;
		bundle.err  = err;
		bundle.done = in_end;
	end
	assign push = accept && (n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_VTOP; dep_q <= '0; node_q <= '0; bc_q <= '0; hex_q <= '0;
			hs_q <= '0; acc_q <= '0; nlen_q <= '0; flg_q <= '0; lit_q <= '0;
			err_q <= jsv_pkg::ERR_OK; stk_q <= '0;
		end else if (accept) begin
			if (stk_we) stk_q[stk_idx] <= stk_val;
			if (in_end) begin
				st_q <= ST_VTOP; dep_q <= '0; node_q <= '0; bc_q <= '0; hex_q <= '0;
				hs_q <= '0; acc_q <= '0; nlen_q <= '0; flg_q <= '0; lit_q <= '0;
				err_q <= jsv_pkg::ERR_OK;
			end else begin
				st_q <= st; dep_q <= dep; node_q <= node; bc_q <= bc; hex_q <= hx;
				hs_q <= hs; acc_q <= acc; nlen_q <= nlen; flg_q <= flg; lit_q <= lit;
				err_q <= err;
			end
		end
	end

endmodule

### sv/jsv_queue.sv
// ----------------------------------------------------------------------------
// jsv_queue
// Short bundle queue between lexer and event serializer.
// ----------------------------------------------------------------------------
module jsv_queue #(
	parameter int DEPTH = jsv_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsv_pkg::bundle_t wdata,
	input  logic             pop,
	output jsv_pkg::bundle_t head,
	output logic             not_empty,
	output logic             full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	jsv_pkg::bundle_t    mem_q [DEPTH];
	logic [AW-1:0]       wp_q, rp_q;
	logic [AW:0]         cnt_q;

	assign head      = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == (AW+1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

### sv/jsv_back.sv
// ----------------------------------------------------------------------------
// jsv_back
// Event serializer: one event beat per cycle from the head bundle while the output is not stalled.
// ----------------------------------------------------------------------------
module jsv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsv_pkg::bundle_t head,
	input  logic             head_valid,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // data_byte, int_value, nest_depth, error_code, done_res
	output logic [3:0]       m_axis_tuser,  // event_res
	output logic             m_axis_tlast   // last_of_run
);

	logic [1:0]    idx_q;
	logic          load, is_last;
	jsv_pkg::ev_t  cur;
	logic          ov_q, done_q, last_q;
	logic [3:0]    code_q;
	logic [7:0]    data_q;
	logic [63:0]   ival_q;
	logic [5:0]    dep_q;
	logic [2:0]    err_q;

	assign cur     = head.ev[idx_q];
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign load    = head_valid && (!ov_q || m_axis_tready);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_axis_tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= cur.code;
			data_q <= cur.data;
			dep_q  <= cur.depth;
			ival_q <= (cur.code == jsv_pkg::EV_INT_END) ? head.ival : 64'd0;
			err_q  <= head.err;
			done_q <= head.done && is_last;
			last_q <= is_last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {6'd0, done_q, err_q, dep_q, ival_q, data_q};
	assign m_axis_tuser  = code_q;
	assign m_axis_tlast  = last_q;

endmodule

### sv/json_stream_validator.sv
// ----------------------------------------------------------------------------
// json_stream_validator
// Streaming JSON syntax checker with token events and limit checks.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the queue is not full; a byte that
// yields k events holds the output for k beats, so sustained rate is bounded
// by the event serializer. A byte's bundle is written into the queue at its
// accept edge, and its event beats are then registered into the output stage.
// Reset: arst_n clears the lexer state, the queue pointers and the output valid
// and index at once; limits return to depth 32, nodes 10000, length 1048576.
module json_stream_validator #(
	parameter int MAX_DEPTH        = jsv_pkg::MAX_DEPTH_DEF,
	parameter int MAX_NUMBER_CHARS = jsv_pkg::MAX_NUMBER_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	input  logic        s_axis_tlast,   // end_of_doc
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,   // data_byte, int_value, nest_depth, error_code, done_res
	output logic [3:0]  m_axis_tuser,   // event_res
	output logic        m_axis_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	logic [5:0]       depth_limit_q;
	logic [13:0]      node_limit_q;
	logic [20:0]      length_limit_q;
	logic             accept, push, pop, not_empty, full;
	jsv_pkg::bundle_t bun, head;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q  <= jsv_pkg::DEPTH_LIMIT_RST;
			node_limit_q   <= jsv_pkg::NODE_LIMIT_RST;
			length_limit_q <= jsv_pkg::LENGTH_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				jsv_pkg::CFG_DEPTH_LIMIT:  depth_limit_q  <= cfg_data[5:0];
				jsv_pkg::CFG_NODE_LIMIT:   node_limit_q   <= cfg_data[13:0];
				jsv_pkg::CFG_LENGTH_LIMIT: length_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	jsv_front #(
		.MAX_DEPTH       (MAX_DEPTH),
		.MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_axis_tdata),
		.in_end      (s_axis_tlast),
		.depth_limit (depth_limit_q),
		.node_limit  (node_limit_q),
		.length_limit(length_limit_q),
		.push        (push),
		.bundle      (bun)
	);

	jsv_queue #(.DEPTH(jsv_pkg::QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (bun),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.full     (full)
	);

	jsv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (not_empty),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

### sv/jsv_checker.sv
// ----------------------------------------------------------------------------
// jsv_checker
// Port-level checks on the event stream of the JSON stream validator.
// ----------------------------------------------------------------------------
module jsv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled beat stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	// done only on the last beat of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[81] |-> m_axis_tlast)
		else $error("done without last");

	// the empty event only closes a document
	a_none_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == jsv_pkg::EV_NONE |-> m_axis_tdata[81] && m_axis_tlast)
		else $error("empty event outside document end");

	// integer field is zero except on integer ends
	a_ival_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != jsv_pkg::EV_INT_END |-> m_axis_tdata[71:8] == 64'd0)
		else $error("integer value on non-integer event");

endmodule

bind json_stream_validator jsv_checker u_jsv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

### tb/json_stream_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_stream_validator_tb
// Streams short JSON documents, well formed, damaged and noisy, through the
// validator under several limit settings. Expected token events come from
// a behavioral lexer in this file and are checked beat by beat.
// ----------------------------------------------------------------------------
module json_stream_validator_tb;

	localparam logic [1:0] CFG_UNMAPPED = 2'd3;
	localparam int         TGT_DEPTH    = 32;
	localparam int         NUM_CHARS    = 64;

	typedef enum int {
		S_VTOP, S_VFIRSTARR, S_VELEM, S_KFIRST, S_KNEXT, S_COLON, S_AFTER,
		S_SCHAR, S_SESC, S_SHEX, S_LOWBS, S_LOWU, S_LOWHEX,
		S_NSIGN, S_NZERO, S_NINT, S_NDOT, S_NFRAC, S_NEXP, S_NEXPSIGN, S_NEXPDIG,
		S_LTRUE, S_LFALSE, S_LNULL
	} lex_e;

	typedef enum logic { K_BYTE, K_CFG } beat_kind_e;

	typedef struct {
		beat_kind_e  kind;
		logic [7:0]  b;
		logic        eod;
		logic [1:0]  idx;
		logic [20:0] val;
	} stim_t;

	typedef struct {
		logic [3:0]  code;
		logic [7:0]  data;
		logic [63:0] ival;
		logic [5:0]  depth;
	} token_t;

	typedef struct {
		token_t      tok;
		logic [2:0]  err;
		logic        done;
		logic        last;
	} token_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [20:0] cfg_data = 21'd0;

	json_stream_validator u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	stim_t      pending[$];
	token_exp_t tokens_due[$];
	token_t     byte_tokens[$];
	logic [7:0] doc_q[$];
	int         errors = 0;
	bit         calm = 1'b0;

	// ---------------- behavioral lexer ----------------
	int          lim_depth, lim_nodes, lim_len;
	logic        stk[TGT_DEPTH];
	int          dep, nodes, nbytes, nlen, lidx;
	lex_e        lx;
	logic [15:0] hexv;
	logic [9:0]  hisur;
	logic [63:0] mag;
	bit          fl_neg, fl_float, fl_key;
	logic [2:0]  err;
	string       words[3] = '{"true", "false", "null"};

	function automatic void clear_doc();
		for (int i = 0; i < TGT_DEPTH; i++) stk[i] = 1'b0;
		dep = 0; nodes = 0; nbytes = 0; lx = S_VTOP; hexv = 0; hisur = 0;
		mag = 0; nlen = 0; fl_neg = 0; fl_float = 0; fl_key = 0; lidx = 0;
		err = jsv_pkg::ERR_OK;
	endfunction

	function automatic void put_tok(logic [3:0] c, logic [7:0] d, logic [63:0] v);
		token_t t;
		if (byte_tokens.size() < 4) begin
			t.code = c; t.data = d; t.ival = v; t.depth = dep[5:0];
			byte_tokens.push_back(t);
		end
	endfunction

	function automatic void flag(logic [2:0] e);
		if (err == jsv_pkg::ERR_OK) err = e;
	endfunction

	function automatic bit take_node();
		if (nodes >= lim_nodes) begin
			flag(jsv_pkg::ERR_NODES);
			return 1'b0;
		end
		nodes++;
		return 1'b1;
	endfunction

	function automatic bit is_ws(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void open_ctr(logic obj);
		int lim;
		lim = lim_depth > TGT_DEPTH ? TGT_DEPTH : lim_depth;
		if (dep >= lim) begin
			flag(jsv_pkg::ERR_DEPTH);
			return;
		end
		if (!take_node()) return;
		stk[dep] = obj;
		dep++;
		put_tok(obj ? jsv_pkg::EV_OBJ_OPEN : jsv_pkg::EV_ARR_OPEN, 8'd0, 64'd0);
		lx = obj ? S_KFIRST : S_VFIRSTARR;
	endfunction

	function automatic void close_ctr(logic obj);
		if (dep == 0 || stk[dep-1] != obj) begin
			flag(jsv_pkg::ERR_SYNTAX);
			return;
		end
		dep--;
		put_tok(obj ? jsv_pkg::EV_OBJ_CLOSE : jsv_pkg::EV_ARR_CLOSE, 8'd0, 64'd0);
		lx = S_AFTER;
	endfunction

	function automatic void count_char();
		nlen++;
		if (nlen >= NUM_CHARS) flag(jsv_pkg::ERR_SYNTAX);
	endfunction

	function automatic void add_digit(logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - "0");
		if (mag > (jsv_pkg::MAG_CAP - d) / 10) mag = jsv_pkg::MAG_CAP;
		else mag = mag * 10 + d;
	endfunction

	function automatic void end_number();
		logic [63:0] v;
		if (!take_node()) return;
		if (fl_float) put_tok(jsv_pkg::EV_FLOAT_END, 8'd0, 64'd0);
		else begin
			if (fl_neg) v = (mag >= jsv_pkg::MAG_CAP) ? jsv_pkg::MAG_CAP : (~mag + 64'd1);
			else v = (mag >= jsv_pkg::MAG_CAP) ? (jsv_pkg::MAG_CAP - 64'd1) : mag;
			put_tok(jsv_pkg::EV_INT_END, 8'd0, v);
		end
		lx = S_AFTER;
	endfunction

	// 1: byte consumed by the number, 0: number ended before this byte
	function automatic bit num_byte(logic [7:0] c);
		bit dg, ex;
		lex_e s;
		s = lx;
		dg = is_dig(c);
		ex = (c == "e" || c == "E");
		if (s == S_NSIGN || s == S_NDOT || s == S_NEXPSIGN) begin
			if (!dg) begin
				flag(jsv_pkg::ERR_SYNTAX);
				return 1'b1;
			end
			if (s == S_NSIGN) begin
				lx = (c == "0") ? S_NZERO : S_NINT;
				add_digit(c);
			end else lx = (s == S_NDOT) ? S_NFRAC : S_NEXPDIG;
			count_char();
			return 1'b1;
		end
		if (s == S_NEXP) begin
			if (c == "+" || c == "-") lx = S_NEXPSIGN;
			else if (dg) lx = S_NEXPDIG;
			else begin
				flag(jsv_pkg::ERR_SYNTAX);
				return 1'b1;
			end
			count_char();
			return 1'b1;
		end
		if (dg && s != S_NZERO) begin
			if (s == S_NINT) add_digit(c);
			count_char();
			return 1'b1;
		end
		if (c == "." && (s == S_NZERO || s == S_NINT)) begin
			fl_float = 1; lx = S_NDOT; count_char();
			return 1'b1;
		end
		if (ex && s != S_NEXPDIG) begin
			fl_float = 1; lx = S_NEXP; count_char();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void put_utf8(logic [20:0] cp);
		if (cp <= 21'h7F) put_tok(jsv_pkg::EV_STR_BYTE, cp[7:0], 64'd0);
		else if (cp <= 21'h7FF) begin
			put_tok(jsv_pkg::EV_STR_BYTE, {3'b110, cp[10:6]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 64'd0);
		end else if (cp <= 21'hFFFF) begin
			put_tok(jsv_pkg::EV_STR_BYTE, {4'b1110, cp[15:12]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[11:6]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 64'd0);
		end else begin
			put_tok(jsv_pkg::EV_STR_BYTE, {5'b11110, cp[20:18]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[17:12]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[11:6]}, 64'd0);
			put_tok(jsv_pkg::EV_STR_BYTE, {2'b10, cp[5:0]}, 64'd0);
		end
	endfunction

	function automatic void take_hex(logic [7:0] c);
		logic [3:0]  v;
		logic [20:0] cp;
		if (c >= "0" && c <= "9") v = 4'(c - "0");
		else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
		else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
		else begin
			flag(jsv_pkg::ERR_SYNTAX);
			return;
		end
		hexv = {hexv[11:0], v};
		lidx++;
		if (lidx < 4) return;
		cp = 21'(hexv);
		if (lx == S_SHEX) begin
			if (hexv >= 16'hD800 && hexv <= 16'hDBFF) begin
				hisur = 10'(hexv - 16'hD800);
				lx = S_LOWBS;
				return;
			end
			if (hexv >= 16'hDC00 && hexv <= 16'hDFFF) begin
				flag(jsv_pkg::ERR_SYNTAX);
				return;
			end
		end else begin
			if (hexv < 16'hDC00 || hexv > 16'hDFFF) begin
				flag(jsv_pkg::ERR_SYNTAX);
				return;
			end
			cp = 21'h10000 + {1'b0, hisur, 10'd0} + 21'(hexv - 16'hDC00);
		end
		put_utf8(cp);
		lx = S_SCHAR;
	endfunction

	function automatic void start_str(bit key);
		fl_key = key; fl_neg = 0; fl_float = 0;
		put_tok(key ? jsv_pkg::EV_KEY_START : jsv_pkg::EV_STR_START, 8'd0, 64'd0);
		lx = S_SCHAR;
	endfunction

	function automatic void start_value(logic [7:0] c);
		if (c == "{") open_ctr(1'b1);
		else if (c == "[") open_ctr(1'b0);
		else if (c == "\"") begin
			if (take_node()) start_str(0);
		end else if (c == "t" || c == "f" || c == "n") begin
			lx = (c == "t") ? S_LTRUE : (c == "f") ? S_LFALSE : S_LNULL;
			lidx = 1;
		end else if (c == "-" || is_dig(c)) begin
			mag = 0; nlen = 1; fl_neg = (c == "-"); fl_float = 0; fl_key = 0;
			if (c == "-") lx = S_NSIGN;
			else begin
				lx = (c == "0") ? S_NZERO : S_NINT;
				add_digit(c);
			end
		end else flag(jsv_pkg::ERR_SYNTAX);
	endfunction

	function automatic void lex_byte(logic [7:0] c);
		lex_e       s;
		int         k;
		logic [7:0] o;
		s = lx;
		if (s >= S_NSIGN && s <= S_NEXPDIG) begin
			if (num_byte(c)) return;
			end_number();
			if (err != jsv_pkg::ERR_OK) return;
			s = S_AFTER;
		end
		if (s <= S_AFTER && is_ws(c)) return;
		case (s)
			S_VTOP, S_VELEM: start_value(c);
			S_VFIRSTARR: if (c == "]") close_ctr(1'b0); else start_value(c);
			S_KFIRST: begin
				if (c == "}") close_ctr(1'b1);
				else if (c == "\"") start_str(1);
				else flag(jsv_pkg::ERR_SYNTAX);
			end
			S_KNEXT: if (c == "\"") start_str(1); else flag(jsv_pkg::ERR_SYNTAX);
			S_COLON: if (c == ":") lx = S_VELEM; else flag(jsv_pkg::ERR_SYNTAX);
			S_AFTER: begin
				if (c == "," && dep > 0) lx = stk[dep-1] ? S_KNEXT : S_VELEM;
				else if (c == "}") close_ctr(1'b1);
				else if (c == "]") close_ctr(1'b0);
				else flag(jsv_pkg::ERR_SYNTAX);
			end
			S_SCHAR: begin
				if (c == "\"") begin
					put_tok(jsv_pkg::EV_STR_END, 8'd0, 64'd0);
					lx = fl_key ? S_COLON : S_AFTER;
				end else if (c == "\\") lx = S_SESC;
				else if (c < 8'h20) flag(jsv_pkg::ERR_SYNTAX);
				else put_tok(jsv_pkg::EV_STR_BYTE, c, 64'd0);
			end
			S_SESC: begin
				case (c)
					"\"", "\\", "/": o = c;
					"b": o = 8'h08;
					"f": o = 8'h0C;
					"n": o = 8'h0A;
					"r": o = 8'h0D;
					"t": o = 8'h09;
					"u": begin
						hexv = 0; lidx = 0; lx = S_SHEX;
						return;
					end
					default: begin
						flag(jsv_pkg::ERR_SYNTAX);
						return;
					end
				endcase
				put_tok(jsv_pkg::EV_STR_BYTE, o, 64'd0);
				lx = S_SCHAR;
			end
			S_SHEX, S_LOWHEX: take_hex(c);
			S_LOWBS: if (c == "\\") lx = S_LOWU; else flag(jsv_pkg::ERR_SYNTAX);
			S_LOWU: begin
				if (c == "u") begin
					hexv = 0; lidx = 0; lx = S_LOWHEX;
				end else flag(jsv_pkg::ERR_SYNTAX);
			end
			S_LTRUE, S_LFALSE, S_LNULL: begin
				k = s - S_LTRUE;
				if (lidx >= words[k].len() || c != words[k][lidx]) begin
					flag(jsv_pkg::ERR_SYNTAX);
					return;
				end
				lidx++;
				if (lidx == words[k].len() && take_node()) begin
					put_tok(k == 0 ? jsv_pkg::EV_TRUE :
						k == 1 ? jsv_pkg::EV_FALSE : jsv_pkg::EV_NULL, 8'd0, 64'd0);
					lx = S_AFTER;
				end
			end
			default: flag(jsv_pkg::ERR_SYNTAX);
		endcase
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic eod);
		token_exp_t e;
		byte_tokens.delete();
		if (nbytes < 21'h1FFFFF) nbytes++;
		if (nbytes > lim_len) err = jsv_pkg::ERR_LEN;
		if (err == jsv_pkg::ERR_OK) lex_byte(c);
		if (eod) begin
			if (err == jsv_pkg::ERR_OK && (lx == S_NZERO || lx == S_NINT ||
					lx == S_NFRAC || lx == S_NEXPDIG))
				end_number();
			if (err == jsv_pkg::ERR_OK && !(lx == S_AFTER && dep == 0))
				flag(jsv_pkg::ERR_SYNTAX);
			if (byte_tokens.size() == 0) put_tok(jsv_pkg::EV_NONE, 8'd0, 64'd0);
		end
		foreach (byte_tokens[i]) begin
			e.tok  = byte_tokens[i];
			e.err  = err;
			e.last = (i == byte_tokens.size() - 1);
			e.done = eod && e.last;
			tokens_due.push_back(e);
		end
		if (eod) clear_doc();
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [20:0] d);
		case (idx)
			jsv_pkg::CFG_DEPTH_LIMIT:  lim_depth = d[5:0];
			jsv_pkg::CFG_NODE_LIMIT:   lim_nodes = d[13:0];
			jsv_pkg::CFG_LENGTH_LIMIT: lim_len = d;
			default: ;
		endcase
	endfunction

	// ---------------- document generator ----------------
	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_ch(logic [3:0] v);
		if (v < 10) return "0" + v;
		return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
	endfunction

	function automatic void add_uesc(logic [15:0] v);
		add_text("\\u");
		for (int i = 3; i >= 0; i--) doc_q.push_back(hex_ch(v[i*4 +: 4]));
	endfunction

	function automatic void add_ws();
		logic [7:0] w[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
		if ($urandom_range(0, 3) == 0) doc_q.push_back(w[$urandom_range(0, 3)]);
	endfunction

	function automatic void gen_string();
		logic [7:0] esc[8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
		logic [7:0] c;
		int n;
		n = $urandom_range(0, 4);
		doc_q.push_back("\"");
		for (int i = 0; i < n; i++)
			case ($urandom_range(0, 7))
				0, 1, 2: begin
					c = 8'($urandom_range(8'h20, 8'h7E));
					doc_q.push_back((c == "\"" || c == "\\") ? "x" : c);
				end
				3: begin
					doc_q.push_back("\\");
					doc_q.push_back(esc[$urandom_range(0, 7)]);
				end
				4: add_uesc($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hD7FF)) :
					16'($urandom_range(16'hE000, 16'hFFFF)));
				5: begin
					add_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
					add_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				6: doc_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
				default: add_uesc(16'($urandom_range(0, 16'h7FF)));
			endcase
		doc_q.push_back("\"");
	endfunction

	function automatic void gen_number();
		int n;
		if ($urandom_range(0, 1)) doc_q.push_back("-");
		case ($urandom_range(0, 5))
			0: doc_q.push_back("0");
			1, 2: begin
				doc_q.push_back(8'($urandom_range("1", "9")));
				n = $urandom_range(0, 4);
				repeat (n) doc_q.push_back(8'($urandom_range("0", "9")));
			end
			3: begin
				// near the int64 bounds
				add_text("92233720368547758");
				repeat ($urandom_range(2, 3)) doc_q.push_back(8'($urandom_range("0", "9")));
			end
			4: begin
				doc_q.push_back("1");
				repeat ($urandom_range(58, 66)) doc_q.push_back(8'($urandom_range("0", "9")));
			end
			default: begin
				doc_q.push_back(8'($urandom_range("0", "9")));
				if ($urandom_range(0, 1)) begin
					doc_q.push_back(".");
					repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range("0", "9")));
				end
				if ($urandom_range(0, 1)) begin
					doc_q.push_back($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: doc_q.push_back("+");
						1: doc_q.push_back("-");
						default: ;
					endcase
					doc_q.push_back(8'($urandom_range("0", "9")));
				end
			end
		endcase
	endfunction

	function automatic void gen_value(int lvl);
		int n;
		add_ws();
		case ($urandom_range(lvl < 3 ? 0 : 2, 8))
			0: begin
				n = $urandom_range(0, 3);
				doc_q.push_back("{");
				for (int i = 0; i < n; i++) begin
					if (i > 0) doc_q.push_back(",");
					add_ws();
					gen_string();
					add_ws();
					doc_q.push_back(":");
					gen_value(lvl + 1);
				end
				add_ws();
				doc_q.push_back("}");
			end
			1: begin
				n = $urandom_range(0, 3);
				doc_q.push_back("[");
				for (int i = 0; i < n; i++) begin
					if (i > 0) doc_q.push_back(",");
					gen_value(lvl + 1);
				end
				doc_q.push_back("]");
			end
			2, 3: gen_string();
			4, 5: gen_number();
			6: add_text("true");
			7: add_text("false");
			default: add_text("null");
		endcase
		add_ws();
	endfunction

	function automatic void queue_doc();
		stim_t it;
		it.kind = K_BYTE; it.idx = 2'd0; it.val = 21'd0;
		foreach (doc_q[i]) begin
			it.b = doc_q[i];
			it.eod = (i == doc_q.size() - 1);
			pending.push_back(it);
		end
		doc_q.delete();
	endfunction

	function automatic void queue_cfg(logic [1:0] idx, logic [20:0] v);
		stim_t it;
		it.kind = K_CFG; it.b = 8'd0; it.eod = 1'b0; it.idx = idx; it.val = v;
		pending.push_back(it);
	endfunction

	function automatic void gen_random_doc();
		int n;
		case ($urandom_range(0, 19))
			0: begin
				// deep nesting around the depth limit
				n = $urandom_range(2, 35);
				repeat (n) doc_q.push_back("[");
				add_text("0");
				repeat (n) doc_q.push_back("]");
			end
			1: repeat ($urandom_range(1, 6)) doc_q.push_back(8'($urandom));
			default: gen_value(0);
		endcase
		n = $urandom_range(0, 19);
		if (n < 3 && doc_q.size() > 0)
			doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom);
		else if (n == 3 && doc_q.size() > 1)
			doc_q = doc_q[0:$urandom_range(0, doc_q.size() - 2)];
		queue_doc();
	endfunction

	// ---------------- clock, reset, stimulus ----------------
	initial forever #4 clk = ~clk;

	initial begin
		int total;
		string directed[8] = '{"{\"k\":[1]}", "-0.5E+3", "\"\\u00e9\\ud83d\\ude00\"",
			"\"\\udc00\"", "tru", "9223372036854775808", "[}", " "};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			add_text(directed[i]);
			queue_doc();
		end
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'd32);
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'd10000);
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'd1048576);
					queue_cfg(CFG_UNMAPPED, 21'd1);
				end
				1: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'd0);
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'h1FFFFF);
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'h1FFFFF);
				end
				2: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'd63);
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'd0);
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'd0);
				end
				3: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'd3);
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'd4);
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'd30);
				end
				4: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'($urandom_range(0, 63)));
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'($urandom_range(0, 20)));
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'($urandom_range(0, 80)));
				end
				default: begin
					queue_cfg(jsv_pkg::CFG_DEPTH_LIMIT, 21'd32);
					queue_cfg(jsv_pkg::CFG_NODE_LIMIT, 21'd16383);
					queue_cfg(jsv_pkg::CFG_LENGTH_LIMIT, 21'd1048576);
				end
			endcase
			total = 0;
			while (total < 63) begin
				gen_random_doc();
				total = 0;
				foreach (pending[i]) if (pending[i].kind == K_BYTE) total++;
				total = total - ph * 63 - 69;
			end
		end

		while (pending.size() > 0 || s_axis_tvalid || cfg_valid || tokens_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("json_stream_validator regression: pass");
		else $display("json_stream_validator regression: fail");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("json_stream_validator regression: fail");
		$finish;
	end

	// ---------------- driver ----------------
	int    src_gap = 0;
	int    quiet = 0;
	bit    nxt_sv, nxt_cv;
	stim_t cur;

	initial begin
		lim_depth = jsv_pkg::DEPTH_LIMIT_RST;
		lim_nodes = jsv_pkg::NODE_LIMIT_RST;
		lim_len   = jsv_pkg::LENGTH_LIMIT_RST;
		clear_doc();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tdata, s_axis_tlast);
			if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
			// results of the last byte may still be in flight
			if (tokens_due.size() == 0 && !s_axis_tvalid) quiet++;
			else quiet = 0;
			calm = pending.size() < 60;
			nxt_sv = 1'b0;
			nxt_cv = 1'b0;
			if ((s_axis_tvalid && !s_axis_tready) || (cfg_valid && !cfg_ready)) begin
				nxt_sv = s_axis_tvalid;
				nxt_cv = cfg_valid;
			end else if (src_gap > 0) src_gap--;
			else if (pending.size() > 0) begin
				cur = pending[0];
				if (cur.kind == K_BYTE) begin
					void'(pending.pop_front());
					nxt_sv = 1'b1;
					s_axis_tdata <= cur.b;
					s_axis_tlast <= cur.eod;
					if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
				end else if (tokens_due.size() == 0 && quiet >= 12) begin
					void'(pending.pop_front());
					nxt_cv = 1'b1;
					cfg_index <= cur.idx;
					cfg_data <= cur.val;
				end
			end
			s_axis_tvalid <= nxt_sv;
			cfg_valid <= nxt_cv;
		end
	end

	// ---------------- monitor ----------------
	int         snk_gap = 0;
	token_exp_t want;

	task automatic chk(string what, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (tokens_due.size() == 0) begin
					$display("%0t unexpected beat: expected none actual event %h", $time,
						m_axis_tuser);
					errors++;
				end else begin
					want = tokens_due.pop_front();
					chk("event", 64'(want.tok.code), 64'(m_axis_tuser));
					chk("data_byte", 64'(want.tok.data), 64'(m_axis_tdata[7:0]));
					chk("int_value", want.tok.ival, m_axis_tdata[71:8]);
					chk("nest_depth", 64'(want.tok.depth), 64'(m_axis_tdata[77:72]));
					chk("error_code", 64'(want.err), 64'(m_axis_tdata[80:78]));
					chk("done", 64'(want.done), 64'(m_axis_tdata[81]));
					chk("last", 64'(want.last), 64'(m_axis_tlast));
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				snk_gap = $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else m_axis_tready <= 1'b1;
		end
	end

endmodule

### files.f
sv/jsv_pkg.sv
sv/jsv_front.sv
sv/jsv_queue.sv
sv/jsv_back.sv
sv/json_stream_validator.sv
sv/jsv_checker.sv
tb/json_stream_validator_tb.sv
